@@ src/ple_pkg.sv @@
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int LEN_OUT_W    = 5;

    localparam logic [2:0] OP_INS_HEAD = 3'd0;
    localparam logic [2:0] OP_APPEND   = 3'd1;
    localparam logic [2:0] OP_INS_POS  = 3'd2;
    localparam logic [2:0] OP_UPDATE   = 3'd3;
    localparam logic [2:0] OP_DELETE   = 3'd4;
    localparam logic [2:0] OP_DUMP     = 3'd5;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_BADPOS = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ACT_HOLD   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_ROTATE = 3'd4
    } t_cell_act;

    typedef struct packed {
        t_cell_act           act;
        logic [VALUE_W-1:0]  value;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ src/positional_list_engine.sv @@
// Channel   Handshake           Payload
// command   start / busy        i_op, i_position, i_value
// result    o_valid (strobe)    o_item_value, o_status, o_length, o_last
//
// A command is taken when start is high and busy is low.
// The result of every edit, error or status command appears in the cycle after it is taken.
// A dump of N elements rotates the cell chain once per element, holding busy while it runs,
// and gives one result per cycle.
// Synchronous active-low reset empties the list; results cannot be stalled by the receiver.
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [2:0]                          i_op,
    input  wire logic [ple_pkg::POS_W-1:0]           i_position,
    input  wire logic signed [ple_pkg::VALUE_W-1:0]  i_value,
    output logic                                     o_valid,
    output logic signed [ple_pkg::VALUE_W-1:0]       o_item_value,
    output logic [1:0]                               o_status,
    output logic [ple_pkg::LEN_OUT_W-1:0]            o_length,
    output logic                                     o_last
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > ple_pkg::POS_W) ? LW : ple_pkg::POS_W) + 1;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
    localparam logic [LW-1:0] ONE_L = LW'(1);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [LW-1:0]                 r_len;
    logic [LW-1:0]                 n_len;
    logic [LW-1:0]                 r_cnt;
    logic [LW-1:0]                 n_cnt;
    logic                          r_valid;
    logic                          n_valid;
    logic [ple_pkg::VALUE_W-1:0]   r_item;
    logic [ple_pkg::VALUE_W-1:0]   n_item;
    ple_pkg::t_status              r_status;
    ple_pkg::t_status              n_status;
    logic                          r_last;
    logic                          n_last;

    ple_pkg::t_cell_cmd            w_cmd;
    logic [LW-1:0]                 w_idx;
    logic [CW-1:0]                 w_pos;
    logic [CW-1:0]                 w_len;
    logic                          w_full;
    logic                          w_accept;
    logic [ple_pkg::VALUE_W-1:0]   w_cell [CAPACITY];

    assign w_pos    = CW'(i_position);
    assign w_len    = CW'(r_len);
    assign w_full   = (r_len == CAP_L);
    assign w_accept = start && (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_valid    = 1'b0;
        n_item     = '0;
        n_status   = ple_pkg::STS_OK;
        n_last     = 1'b1;
        w_cmd.act   = ple_pkg::ACT_HOLD;
        w_cmd.value = i_value;
        w_idx      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_valid = 1'b1;
                    unique case (i_op)
                        ple_pkg::OP_INS_HEAD: begin
                            if (w_full) begin
                                n_status = ple_pkg::STS_FULL;
                            end else begin
                                w_cmd.act = ple_pkg::ACT_INSERT;
                                w_idx     = '0;
                                n_len     = r_len + ONE_L;
                            end
                        end
                        ple_pkg::OP_APPEND: begin
                            if (w_full) begin
                                n_status = ple_pkg::STS_FULL;
                            end else begin
                                w_cmd.act = ple_pkg::ACT_INSERT;
                                w_idx     = r_len;
                                n_len     = r_len + ONE_L;
                            end
                        end
                        ple_pkg::OP_INS_POS: begin
                            if (w_pos == '0 || w_pos > w_len + ONE_C) begin
                                n_status = ple_pkg::STS_BADPOS;
                            end else if (w_full) begin
                                n_status = ple_pkg::STS_FULL;
                            end else begin
                                w_cmd.act = ple_pkg::ACT_INSERT;
                                w_idx     = LW'(w_pos - ONE_C);
                                n_len     = r_len + ONE_L;
                            end
                        end
                        ple_pkg::OP_UPDATE: begin
                            if (r_len == '0) begin
                                n_status = ple_pkg::STS_EMPTY;
                            end else if (w_pos == '0 || w_pos > w_len) begin
                                n_status = ple_pkg::STS_BADPOS;
                            end else begin
                                w_cmd.act = ple_pkg::ACT_UPDATE;
                                w_idx     = LW'(w_pos - ONE_C);
                            end
                        end
                        ple_pkg::OP_DELETE: begin
                            if (r_len == '0) begin
                                n_status = ple_pkg::STS_EMPTY;
                            end else if (w_pos == '0 || w_pos > w_len) begin
                                n_status = ple_pkg::STS_BADPOS;
                            end else begin
                                w_cmd.act = ple_pkg::ACT_DELETE;
                                w_idx     = LW'(w_pos - ONE_C);
                                n_len     = r_len - ONE_L;
                            end
                        end
                        ple_pkg::OP_DUMP: begin
                            if (r_len == '0) begin
                                n_status = ple_pkg::STS_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_cnt   = '0;
                                n_state = ST_DUMP;
                            end
                        end
                        default: begin
                            n_status = ple_pkg::STS_OK;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                w_cmd.act = ple_pkg::ACT_ROTATE;
                n_valid   = 1'b1;
                n_item    = w_cell[0];
                n_last    = (r_cnt + ONE_L == r_len);
                n_cnt     = r_cnt + ONE_L;
                if (n_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_status <= n_status;
        r_last   <= n_last;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ple_pkg::VALUE_W-1:0] w_prev;
        logic [ple_pkg::VALUE_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = i_value;
        end else begin : g_mid_prev
            assign w_prev = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_next = w_cell[g];
        end else begin : g_mid_next
            assign w_next = w_cell[g+1];
        end
        ple_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_idx   (w_idx),
            .i_len   (r_len),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_cell[0]),
            .o_value (w_cell[g])
        );
    end

    assign busy         = (r_state == ST_DUMP);
    assign o_valid      = r_valid;
    assign o_item_value = r_item;
    assign o_status     = r_status;
    assign o_length     = ple_pkg::LEN_OUT_W'(r_len);
    assign o_last       = r_last;

endmodule

`default_nettype wire

@@ src/ple_cell.sv @@
`default_nettype none

module ple_cell #(
    parameter int IDX = 0,
    parameter int LW  = 5
) (
    input  wire logic                         i_clk,
    input  wire ple_pkg::t_cell_cmd           i_cmd,
    input  wire logic [LW-1:0]                i_idx,
    input  wire logic [LW-1:0]                i_len,
    input  wire logic [ple_pkg::VALUE_W-1:0]  i_prev,
    input  wire logic [ple_pkg::VALUE_W-1:0]  i_next,
    input  wire logic [ple_pkg::VALUE_W-1:0]  i_head,
    output logic      [ple_pkg::VALUE_W-1:0]  o_value
);

    localparam logic [LW-1:0] IDX_L = LW'(IDX);
    localparam logic [LW-1:0] IDX_N = LW'(IDX + 1);

    logic [ple_pkg::VALUE_W-1:0] r_value;
    logic [ple_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_cmd.act)
            ple_pkg::ACT_INSERT: begin
                if (IDX_L == i_idx) begin
                    n_value = i_cmd.value;
                end else if (IDX_L > i_idx && IDX_L <= i_len) begin
                    n_value = i_prev;
                end
            end
            ple_pkg::ACT_UPDATE: begin
                if (IDX_L == i_idx) begin
                    n_value = i_cmd.value;
                end
            end
            ple_pkg::ACT_DELETE: begin
                if (IDX_L >= i_idx && IDX_N < i_len) begin
                    n_value = i_next;
                end
            end
            ple_pkg::ACT_ROTATE: begin
                if (IDX_N < i_len) begin
                    n_value = i_next;
                end else if (IDX_N == i_len) begin
                    n_value = i_head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = ple_pkg::CAPACITY_DEF;
    localparam int N_DIRECTED = 23;
    localparam int N_RANDOM   = 280;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 24;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} t_mix;

    typedef struct packed {
        logic signed [ple_pkg::VALUE_W-1:0] item;
        ple_pkg::t_status                   status;
        logic [ple_pkg::LEN_OUT_W-1:0]      length;
        logic                               last;
    } t_list_result;

    typedef struct packed {
        logic [2:0]                         op;
        logic [ple_pkg::POS_W-1:0]          pos;
        logic signed [ple_pkg::VALUE_W-1:0] val;
        logic                               typed;
        ple_pkg::t_status                   status;
        logic [ple_pkg::LEN_OUT_W-1:0]      length;
    } t_dir_row;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   start;
    logic                                   busy;
    logic [2:0]                             i_op;
    logic [ple_pkg::POS_W-1:0]              i_position;
    logic signed [ple_pkg::VALUE_W-1:0]     i_value;
    logic                                   o_valid;
    logic signed [ple_pkg::VALUE_W-1:0]     o_item_value;
    logic [1:0]                             o_status;
    logic [ple_pkg::LEN_OUT_W-1:0]          o_length;
    logic                                   o_last;

    logic signed [ple_pkg::VALUE_W-1:0]     list_cells [CAP];
    int unsigned                            list_len;
    t_list_result                           pending_results [$];
    t_list_result                           oldest;
    int                                     outstanding;
    int                                     len_for_stim;
    int                                     fail_count;
    int                                     idle_cycles;
    int                                     send_idle_pct;
    logic                                   typed_pending;
    t_list_result                           typed_expect;
    t_dir_row                               directed_rows [N_DIRECTED];

    positional_list_engine #(.CAPACITY(CAP)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_item_value (o_item_value),
        .o_status     (o_status),
        .o_length     (o_length),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void open_slot(input int unsigned idx,
                                      input logic signed [ple_pkg::VALUE_W-1:0] val);
        for (int unsigned i = list_len; i > idx; i--) begin
            list_cells[i] = list_cells[i - 1];
        end
        list_cells[idx] = val;
        list_len++;
    endfunction

    function automatic void apply_list_op(input logic [2:0] op,
                                          input logic [ple_pkg::POS_W-1:0] pos,
                                          input logic signed [ple_pkg::VALUE_W-1:0] val);
        ple_pkg::t_status st;
        st = ple_pkg::STS_OK;
        case (op)
            ple_pkg::OP_INS_HEAD: begin
                if (list_len >= CAP) st = ple_pkg::STS_FULL;
                else open_slot(0, val);
            end
            ple_pkg::OP_APPEND: begin
                if (list_len >= CAP) st = ple_pkg::STS_FULL;
                else open_slot(list_len, val);
            end
            ple_pkg::OP_INS_POS: begin
                if (pos == 0 || pos > list_len + 1) st = ple_pkg::STS_BADPOS;
                else if (list_len >= CAP) st = ple_pkg::STS_FULL;
                else open_slot(pos - 1, val);
            end
            ple_pkg::OP_UPDATE: begin
                if (list_len == 0) st = ple_pkg::STS_EMPTY;
                else if (pos == 0 || pos > list_len) st = ple_pkg::STS_BADPOS;
                else list_cells[pos - 1] = val;
            end
            ple_pkg::OP_DELETE: begin
                if (list_len == 0) st = ple_pkg::STS_EMPTY;
                else if (pos == 0 || pos > list_len) st = ple_pkg::STS_BADPOS;
                else begin
                    for (int unsigned i = pos - 1; i + 1 < list_len; i++) begin
                        list_cells[i] = list_cells[i + 1];
                    end
                    list_len--;
                end
            end
            ple_pkg::OP_DUMP: begin
                if (list_len == 0) begin
                    pending_results.push_back(t_list_result'{item: '0,
                        status: ple_pkg::STS_EMPTY, length: '0, last: 1'b1});
                end else begin
                    for (int unsigned i = 0; i < list_len; i++) begin
                        pending_results.push_back(t_list_result'{item: list_cells[i],
                            status: ple_pkg::STS_OK,
                            length: list_len[ple_pkg::LEN_OUT_W-1:0],
                            last: (i + 1 == list_len)});
                    end
                end
                return;
            end
            default: ;
        endcase
        pending_results.push_back(t_list_result'{item: '0, status: st,
            length: list_len[ple_pkg::LEN_OUT_W-1:0], last: 1'b1});
    endfunction

    function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic void pick_command(input t_mix mix, output logic [2:0] op,
                                         output logic [ple_pkg::POS_W-1:0] pos);
        int roll;
        int n;
        roll = $urandom_range(99);
        n = len_for_stim;
        if (roll < 5) begin
            op = 3'($urandom_range(7));
            pos = ple_pkg::POS_W'($urandom_range(31));
            return;
        end
        if (roll < 13) begin
            op = ple_pkg::OP_DUMP;
            pos = ple_pkg::POS_W'($urandom_range(31));
            return;
        end
        roll = $urandom_range(99);
        case (mix)
            MIX_GROW:
                op = (roll < 30) ? ple_pkg::OP_APPEND : (roll < 55) ? ple_pkg::OP_INS_HEAD :
                     (roll < 85) ? ple_pkg::OP_INS_POS : (roll < 95) ? ple_pkg::OP_UPDATE :
                     ple_pkg::OP_DELETE;
            MIX_SHRINK:
                op = (roll < 70) ? ple_pkg::OP_DELETE : (roll < 85) ? ple_pkg::OP_UPDATE :
                     (roll < 92) ? ple_pkg::OP_INS_POS : ple_pkg::OP_APPEND;
            default:
                op = (roll < 20) ? ple_pkg::OP_APPEND : (roll < 40) ? ple_pkg::OP_INS_HEAD :
                     (roll < 60) ? ple_pkg::OP_INS_POS : (roll < 80) ? ple_pkg::OP_UPDATE :
                     ple_pkg::OP_DELETE;
        endcase
        if (op == ple_pkg::OP_INS_POS) begin
            if ($urandom_range(9) == 0) begin
                pos = ple_pkg::POS_W'($urandom_range(1) ? 0 : $urandom_range(31, n + 2));
            end else begin
                pos = ple_pkg::POS_W'($urandom_range(n + 1, 1));
            end
        end else begin
            if ($urandom_range(9) == 0) begin
                pos = ple_pkg::POS_W'($urandom_range(1) ? 0 : $urandom_range(31, n + 1));
            end else begin
                pos = ple_pkg::POS_W'($urandom_range((n > 0) ? n : 1, 1));
            end
        end
    endfunction

    task automatic send_command(input logic [2:0] op, input logic [ple_pkg::POS_W-1:0] pos,
                                input logic signed [ple_pkg::VALUE_W-1:0] val,
                                input logic typed, input t_list_result typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_position    <= pos;
        i_value       <= val;
        typed_pending <= typed;
        typed_expect  <= typed_res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: item_value %0d status %0d length %0d last %0d",
                           o_item_value, o_status, o_length, o_last);
                    fail_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (o_item_value !== oldest.item) begin
                        $error("item_value: expected %0d, got %0d", oldest.item, o_item_value);
                        fail_count++;
                    end
                    if (o_status !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, o_status);
                        fail_count++;
                    end
                    if (o_length !== oldest.length) begin
                        $error("length: expected %0d, got %0d", oldest.length, o_length);
                        fail_count++;
                    end
                    if (o_last !== oldest.last) begin
                        $error("last: expected %0d, got %0d", oldest.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                apply_list_op(i_op, i_position, i_value);
                // A row with a typed-in answer replaces the single predicted status result.
                if (typed_pending) begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(typed_expect);
                end
            end
            outstanding  <= pending_results.size();
            len_for_stim <= list_len;
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [2:0]                op;
        logic [ple_pkg::POS_W-1:0] pos;
        t_list_result              typed_res;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = ple_pkg::OP_INS_HEAD;
        i_position    = '0;
        i_value       = '0;
        typed_pending = 1'b0;
        typed_expect  = '0;
        list_len      = 0;
        outstanding   = 0;
        len_for_stim  = 0;
        fail_count    = 0;
        idle_cycles   = 0;
        send_idle_pct = 29;
        foreach (list_cells[i]) list_cells[i] = '0;

        directed_rows = '{
            '{ple_pkg::OP_DUMP,     5'd0,  32'sh0000_0000, 1'b1, ple_pkg::STS_EMPTY,  5'd0},
            '{ple_pkg::OP_DELETE,   5'd1,  32'sh0000_0000, 1'b1, ple_pkg::STS_EMPTY,  5'd0},
            '{ple_pkg::OP_UPDATE,   5'd1,  32'sh0000_0001, 1'b1, ple_pkg::STS_EMPTY,  5'd0},
            '{ple_pkg::OP_INS_POS,  5'd0,  32'sh0000_0002, 1'b1, ple_pkg::STS_BADPOS, 5'd0},
            '{ple_pkg::OP_INS_POS,  5'd2,  32'sh0000_0003, 1'b1, ple_pkg::STS_BADPOS, 5'd0},
            '{ple_pkg::OP_INS_POS,  5'd1,  32'sh7FFF_FFFF, 1'b1, ple_pkg::STS_OK,     5'd1},
            '{ple_pkg::OP_INS_HEAD, 5'd0,  32'sh8000_0000, 1'b1, ple_pkg::STS_OK,     5'd2},
            '{ple_pkg::OP_APPEND,   5'd31, 32'shFFFF_FFFF, 1'b1, ple_pkg::STS_OK,     5'd3},
            '{ple_pkg::OP_INS_POS,  5'd4,  32'sh0000_0000, 1'b1, ple_pkg::STS_OK,     5'd4},
            '{ple_pkg::OP_DUMP,     5'd0,  32'sh0000_0000, 1'b0, ple_pkg::STS_OK,     5'd0},
            '{OP_SPARE_6,           5'd31, 32'shFFFF_FFFF, 1'b1, ple_pkg::STS_OK,     5'd4},
            '{OP_SPARE_7,           5'd1,  32'sh0000_0000, 1'b1, ple_pkg::STS_OK,     5'd4},
            '{ple_pkg::OP_UPDATE,   5'd0,  32'sh0000_0004, 1'b1, ple_pkg::STS_BADPOS, 5'd4},
            '{ple_pkg::OP_UPDATE,   5'd5,  32'sh0000_0005, 1'b1, ple_pkg::STS_BADPOS, 5'd4},
            '{ple_pkg::OP_DELETE,   5'd31, 32'sh0000_0000, 1'b1, ple_pkg::STS_BADPOS, 5'd4},
            '{ple_pkg::OP_UPDATE,   5'd4,  32'sh5555_5555, 1'b1, ple_pkg::STS_OK,     5'd4},
            '{ple_pkg::OP_UPDATE,   5'd1,  32'shAAAA_AAAA, 1'b1, ple_pkg::STS_OK,     5'd4},
            '{ple_pkg::OP_DELETE,   5'd1,  32'sh0000_0000, 1'b1, ple_pkg::STS_OK,     5'd3},
            '{ple_pkg::OP_DELETE,   5'd3,  32'sh0000_0000, 1'b1, ple_pkg::STS_OK,     5'd2},
            '{ple_pkg::OP_APPEND,   5'd0,  32'sh0000_0001, 1'b1, ple_pkg::STS_OK,     5'd3},
            '{ple_pkg::OP_DUMP,     5'd0,  32'sh0000_0000, 1'b0, ple_pkg::STS_OK,     5'd0},
            '{ple_pkg::OP_INS_POS,  5'd2,  32'sh0001_2345, 1'b0, ple_pkg::STS_OK,     5'd0},
            '{ple_pkg::OP_DUMP,     5'd0,  32'sh0000_0000, 1'b0, ple_pkg::STS_OK,     5'd0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            typed_res = t_list_result'{item: '0, status: directed_rows[r].status,
                                       length: directed_rows[r].length, last: 1'b1};
            send_command(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].val,
                         directed_rows[r].typed, typed_res);
        end
        drain_results();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 47 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) begin
                pick_command(t_mix'((k / 24) % 3), op, pos);
                send_command(op, pos, pick_value(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/ple_pkg.sv
src/ple_cell.sv
src/positional_list_engine.sv
dv/tb.sv
